### rtl/core/kwr_pkg.sv
// Shared types and constants of the k weakest rows selector.
package kwr_pkg;

    localparam int CNT_W     = 7;
    localparam int K_W       = 5;
    localparam int COLS_W    = 7;
    localparam int OUT_IDX_W = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_K_SELECT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_IN_USE = 1'd1;

    localparam logic [K_W-1:0]    K_SELECT_RESET = 5'd1;
    localparam logic [COLS_W-1:0] COLUMNS_RESET  = 7'd64;

endpackage

### rtl/core/kwr_front.sv
// Front end: accepts rows, counts leading ones and numbers the rows.
module kwr_front import kwr_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 1024,
    parameter int IDX_W    = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [63:0]         i_row_bits,
    input  logic                i_last_row,
    input  logic [COLS_W-1:0]   i_columns_in_use,
    input  logic                i_queue_full,
    output logic                o_push,
    output logic                o_keep,
    output logic                o_last,
    output logic [CNT_W-1:0]    o_count,
    output logic [IDX_W-1:0]    o_index
);

    localparam int CTR_W = $clog2(MAX_ROWS + 1);

    logic [CTR_W-1:0]  r_row_ctr;
    logic [CTR_W-1:0]  n_row_ctr;
    logic [COLS_W-1:0] cols_eff;
    logic [CNT_W-1:0]  ones;
    logic              accept;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    always_comb begin
        if (i_columns_in_use == '0) begin
            cols_eff = COLS_W'(1);
        end else if (int'(i_columns_in_use) > MAX_COLS) begin
            cols_eff = COLS_W'(MAX_COLS);
        end else begin
            cols_eff = i_columns_in_use;
        end
    end

    // The first column that is a zero or lies past the valid columns ends the run.
    always_comb begin
        ones = CNT_W'(MAX_COLS);
        for (int j = MAX_COLS - 1; j >= 0; j--) begin
            if (!(i_row_bits[j] && (j < int'(cols_eff)))) begin
                ones = CNT_W'(j);
            end
        end
    end

    always_comb begin
        n_row_ctr = r_row_ctr;
        if (accept) begin
            if (i_last_row) begin
                n_row_ctr = '0;
            end else if (int'(r_row_ctr) < MAX_ROWS) begin
                n_row_ctr = r_row_ctr + CTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ctr <= '0;
        end else begin
            r_row_ctr <= n_row_ctr;
        end
    end

    assign o_push  = accept;
    assign o_keep  = int'(r_row_ctr) < MAX_ROWS;
    assign o_last  = i_last_row;
    assign o_count = ones;
    assign o_index = IDX_W'(r_row_ctr);

endmodule

### rtl/core/kwr_queue.sv
// Short queue between the front end and the selection store.
module kwr_queue #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_fill;

    assign o_full  = int'(r_fill) == DEPTH;
    assign o_empty = r_fill == '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (int'(r_wr) == DEPTH - 1) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (int'(r_rd) == DEPTH - 1) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + CW'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

endmodule

### rtl/core/kwr_back.sv
// Back end: sorted insertion store and the report that drains it.
module kwr_back import kwr_pkg::*; #(
    parameter int MAX_K = 16,
    parameter int IDX_W = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    output logic                 o_item_pop,
    input  logic                 i_keep,
    input  logic                 i_last,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [IDX_W-1:0]     i_index,
    input  logic [K_W-1:0]       i_k_select,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [OUT_IDX_W-1:0] o_row_index,
    output logic [CNT_W-1:0]     o_soldier_count,
    output logic                 o_last_result
);

    localparam int HW = $clog2(MAX_K + 1);

    typedef enum logic {ST_RUN, ST_DRAIN} t_state;

    t_state           r_state;
    logic [HW-1:0]    r_held;
    logic [HW-1:0]    r_left;
    logic [CNT_W-1:0] r_cnt [MAX_K];
    logic [IDX_W-1:0] r_idx [MAX_K];
    logic [CNT_W-1:0] n_cnt [MAX_K];
    logic [IDX_W-1:0] n_idx [MAX_K];
    logic [CNT_W-1:0] sh_cnt [MAX_K];
    logic [IDX_W-1:0] sh_idx [MAX_K];
    logic [MAX_K-1:0] le;
    logic [MAX_K:0]   le_ext;
    logic [HW-1:0]    held_ins;
    logic [HW-1:0]    k_eff;
    logic [HW-1:0]    report_n;
    logic             pop;
    logic             insert;
    logic             out_load;
    logic             drain_step;

    assign pop        = (r_state == ST_RUN) && i_item_valid;
    assign insert     = pop && i_keep;
    assign o_item_pop = pop;
    assign out_load   = !o_out_valid || !i_out_stall;
    assign drain_step = (r_state == ST_DRAIN) && out_load;

    always_comb begin
        if (i_k_select == '0) begin
            k_eff = HW'(1);
        end else if (int'(i_k_select) > MAX_K) begin
            k_eff = HW'(MAX_K);
        end else begin
            k_eff = HW'(i_k_select);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            le[i] = (i < int'(r_held)) && (r_cnt[i] <= i_count);
        end
        le_ext = {le, 1'b1};
        sh_cnt[0] = i_count;
        sh_idx[0] = i_index;
        for (int i = 1; i < MAX_K; i++) begin
            sh_cnt[i] = r_cnt[i-1];
            sh_idx[i] = r_idx[i-1];
        end
    end

    // Each cell keeps its entry, takes the new row, or takes its neighbor's entry.
    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (insert) begin
            for (int i = 0; i < MAX_K; i++) begin
                if (!le[i] && le_ext[i]) begin
                    n_cnt[i] = i_count;
                    n_idx[i] = i_index;
                end else if (!le[i]) begin
                    n_cnt[i] = sh_cnt[i];
                    n_idx[i] = sh_idx[i];
                end
            end
        end else if (drain_step) begin
            for (int i = 0; i < MAX_K - 1; i++) begin
                n_cnt[i] = r_cnt[i+1];
                n_idx[i] = r_idx[i+1];
            end
        end
    end

    always_comb begin
        held_ins = r_held;
        if (insert && (int'(r_held) < MAX_K)) begin
            held_ins = r_held + HW'(1);
        end
        report_n = (k_eff < held_ins) ? k_eff : held_ins;
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_held      <= '0;
            r_left      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_RUN: begin
                    if (pop) begin
                        if (i_last) begin
                            r_left <= report_n;
                            if (report_n == '0) begin
                                r_held <= '0;
                            end else begin
                                r_held  <= held_ins;
                                r_state <= ST_DRAIN;
                            end
                        end else begin
                            r_held <= held_ins;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (out_load) begin
                        o_out_valid     <= 1'b1;
                        o_row_index     <= OUT_IDX_W'(r_idx[0]);
                        o_soldier_count <= r_cnt[0];
                        o_last_result   <= r_left == HW'(1);
                        r_left          <= r_left - HW'(1);
                        if (r_left == HW'(1)) begin
                            r_held  <= '0;
                            r_state <= ST_RUN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

endmodule

### rtl/core/k_weakest_rows_select.sv
// Top level of the k weakest rows selector: configuration registers and the datapath.
//
// Each accepted word is one matrix row; the block counts its leading ones and files the
// row into a sorted store of the MAX_K weakest rows, ties going to the earlier row. The
// store's compare-and-shift insertion takes one row per cycle. On the word marked as the
// last row, the block reports min(k_select, rows held) words, a k_select of zero counting
// as one, from weakest to strongest, one per cycle while the output is not stalled, and
// flags the final one; while the report drains the store takes no rows, and the
// two-entry queue behind the front end absorbs the next rows before the input stalls.
module k_weakest_rows_select import kwr_pkg::*; #(
    parameter int MAX_K    = 16,
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [63:0]          i_row_bits,
    input  logic                 i_last_row,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [OUT_IDX_W-1:0] o_row_index,
    output logic [CNT_W-1:0]     o_soldier_count,
    output logic                 o_last_result
);

    localparam int IDX_W = $clog2(MAX_ROWS);
    localparam int QW    = 2 + CNT_W + IDX_W;

    logic [K_W-1:0]    r_k_select;
    logic [COLS_W-1:0] r_columns_in_use;
    logic              f_push;
    logic              f_keep;
    logic              f_last;
    logic [CNT_W-1:0]  f_count;
    logic [IDX_W-1:0]  f_index;
    logic [QW-1:0]     q_out;
    logic              q_full;
    logic              q_empty;
    logic              b_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_select       <= K_SELECT_RESET;
            r_columns_in_use <= COLUMNS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_K_SELECT:       r_k_select       <= i_cfg_data[K_W-1:0];
                CFG_COLUMNS_IN_USE: r_columns_in_use <= i_cfg_data[COLS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    kwr_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .IDX_W    (IDX_W)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_row_bits       (i_row_bits),
        .i_last_row       (i_last_row),
        .i_columns_in_use (r_columns_in_use),
        .i_queue_full     (q_full),
        .o_push           (f_push),
        .o_keep           (f_keep),
        .o_last           (f_last),
        .o_count          (f_count),
        .o_index          (f_index)
    );

    kwr_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_keep, f_last, f_count, f_index}),
        .i_pop   (b_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    kwr_back #(
        .MAX_K (MAX_K),
        .IDX_W (IDX_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (!q_empty),
        .o_item_pop      (b_pop),
        .i_keep          (q_out[QW-1]),
        .i_last          (q_out[QW-2]),
        .i_count         (q_out[IDX_W +: CNT_W]),
        .i_index         (q_out[IDX_W-1:0]),
        .i_k_select      (r_k_select),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_row_index     (o_row_index),
        .o_soldier_count (o_soldier_count),
        .o_last_result   (o_last_result)
    );

endmodule

### tb/kwr_board_pkg.sv
// Scoreboard class for the k weakest rows selector: predicts each reported word and checks it.
`timescale 1ns / 1ps
package kwr_board_pkg;
    import kwr_pkg::*;

    localparam int BEST_DEPTH = 16;
    localparam int ROW_LIMIT  = 1024;
    localparam int COL_LIMIT  = 64;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] row_index;
        logic [CNT_W-1:0]     soldiers;
        logic                 last;
    } t_report_word;

    class weak_row_board;
        logic [CNT_W-1:0]  best_count[BEST_DEPTH];
        logic [10:0]       best_row[BEST_DEPTH];
        int unsigned       held;
        logic [10:0]       next_row;
        logic [K_W-1:0]    k_reg;
        logic [COLS_W-1:0] cols_reg;
        t_report_word      pending_words[$];
        int unsigned       mismatches;
        int unsigned       words_checked;

        function new();
            held          = 0;
            next_row      = '0;
            k_reg         = K_SELECT_RESET;
            cols_reg      = COLUMNS_RESET;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] data);
            if (idx == CFG_K_SELECT) begin
                k_reg = data[K_W-1:0];
            end else if (idx == CFG_COLUMNS_IN_USE) begin
                cols_reg = data[COLS_W-1:0];
            end
        endfunction

        function int unsigned count_soldiers(input logic [63:0] bits);
            int unsigned cols;
            int unsigned n;
            cols = (cols_reg == 0) ? 1 : ((cols_reg > COL_LIMIT) ? COL_LIMIT : cols_reg);
            n = 0;
            while (n < cols && bits[n]) n++;
            return n;
        endfunction

        function void file_row(input int unsigned count, input logic [10:0] row);
            int unsigned pos;
            int unsigned i;
            pos = 0;
            while (pos < held && best_count[pos] <= count) pos++;
            if (pos >= BEST_DEPTH) return;
            i = (held < BEST_DEPTH) ? held : BEST_DEPTH - 1;
            while (i > pos) begin
                best_count[i] = best_count[i-1];
                best_row[i]   = best_row[i-1];
                i--;
            end
            best_count[pos] = CNT_W'(count);
            best_row[pos]   = row;
            if (held < BEST_DEPTH) held++;
        endfunction

        function void note_row(input logic [63:0] bits, input logic last);
            int unsigned  k_eff;
            int unsigned  n;
            t_report_word w;
            if (next_row < ROW_LIMIT) begin
                file_row(count_soldiers(bits), next_row);
                next_row++;
            end
            if (!last) return;
            k_eff = (k_reg == 0) ? 1 : ((k_reg > BEST_DEPTH) ? BEST_DEPTH : k_reg);
            n = (k_eff < held) ? k_eff : held;
            for (int i = 0; i < n; i++) begin
                w.row_index = best_row[i][OUT_IDX_W-1:0];
                w.soldiers  = best_count[i];
                w.last      = (i + 1 == n);
                pending_words.insert(pending_words.size(), w);
            end
            held     = 0;
            next_row = '0;
        endfunction

        function void check_word(input logic [OUT_IDX_W-1:0] row_index,
                                 input logic [CNT_W-1:0] soldiers, input logic last);
            t_report_word w;
            words_checked++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected word: row %0d count %0d last %0b",
                             row_index, soldiers, last);
                return;
            end
            w = pending_words.pop_front();
            if (w.row_index !== row_index || w.soldiers !== soldiers || w.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display(
                        "Mismatch: expected row %0d count %0d last %0b, got %0d %0d %0b",
                        w.row_index, w.soldiers, w.last, row_index, soldiers, last);
            end
        endfunction
    endclass

endpackage

### tb/tb_top.sv
// Top-level testbench of the k weakest rows selector: stimulus, flow control and final verdict.
`timescale 1ns / 1ps
module tb_top;
    import kwr_pkg::*;
    import kwr_board_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ROWS   = 300;

    typedef enum {FLOW_FREE, FLOW_COIN, FLOW_HEAVY, FLOW_PERIODIC} t_flow_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [63:0]          i_row_bits;
    logic                 i_last_row;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [OUT_IDX_W-1:0] o_row_index;
    logic [CNT_W-1:0]     o_soldier_count;
    logic                 o_last_result;

    weak_row_board board;
    int unsigned   cycle_count   = 0;
    int unsigned   rows_sent     = 0;
    int unsigned   matrices_sent = 0;
    int unsigned   settings_used = 0;
    int unsigned   burst_left    = 0;
    logic          hold_start    = 1'b0;
    bit            hold_used     = 1'b0;
    int unsigned   hold_left     = 0;
    int unsigned   mode_left     = 0;
    t_flow_mode    flow_mode     = FLOW_FREE;

    k_weakest_rows_select dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_row_bits      (i_row_bits),
        .i_last_row      (i_last_row),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_row_index     (o_row_index),
        .o_soldier_count (o_soldier_count),
        .o_last_result   (o_last_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_word(o_row_index, o_soldier_count, o_last_result);
    end

    always @(posedge i_clk) begin
        if (hold_start && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                flow_mode = t_flow_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            case (flow_mode)
                FLOW_FREE:  i_out_stall <= 1'b0;
                FLOW_COIN:  i_out_stall <= ($urandom_range(0, 1) == 0);
                FLOW_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:    i_out_stall <= cycle_count[2];
            endcase
        end
    end

    function automatic logic [63:0] sorted_row(input int unsigned ones);
        return (ones >= 64) ? '1 : ((64'd1 << ones) - 64'd1);
    endfunction

    function automatic logic [63:0] random_row();
        logic [63:0] bits;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
            bits = sorted_row($urandom_range(0, 64));
        end else if (pick < 18) begin
            bits = {$urandom, $urandom};
        end else begin
            bits = sorted_row($urandom_range(1, 64));
            bits[$urandom_range(0, 63)] ^= 1'b1;
        end
        return bits;
    endfunction

    task automatic send_row(input logic [63:0] bits, input logic last);
        i_in_valid <= 1'b1;
        i_row_bits <= bits;
        i_last_row <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_row(bits, last);
        rows_sent++;
        if (last) matrices_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic send_matrix(input int unsigned rows);
        for (int r = 0; r < rows; r++)
            send_row(random_row(), r == rows - 1);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [K_W-1:0] k, input logic [COLS_W-1:0] cols);
        logic [CFG_W-1:0] k_data;
        k_data = {2'($urandom_range(0, 3)), k};
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_K_SELECT;
        i_cfg_data  <= k_data;
        @(posedge i_clk);
        board.set_register(CFG_K_SELECT, k_data);
        i_cfg_index <= CFG_COLUMNS_IN_USE;
        i_cfg_data  <= cols;
        @(posedge i_clk);
        board.set_register(CFG_COLUMNS_IN_USE, cols);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [K_W-1:0] pick_k();
        case ($urandom_range(0, 7))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'd31;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [COLS_W-1:0] pick_cols();
        case ($urandom_range(0, 7))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'd127;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    initial begin
        int unsigned random_start;
        board = new();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_K_SELECT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_row_bits  <= '0;
        i_last_row  <= 1'b0;
        i_out_stall <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one reported word, all 64 columns.
        send_row('1, 1'b0);
        send_row(64'h0, 1'b0);
        send_row(64'h7, 1'b1);
        wait_idle();

        // Full report with ties, an all-ones row, an empty row and unsorted rows.
        apply_setting(5'd16, 7'd64);
        send_row(sorted_row(3), 1'b0);
        send_row(sorted_row(3), 1'b0);
        send_row(sorted_row(1), 1'b0);
        send_row(sorted_row(3), 1'b0);
        send_row('1, 1'b0);
        send_row(64'h0, 1'b0);
        send_row(64'hB, 1'b0);
        send_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        send_row(sorted_row(1), 1'b1);
        wait_idle();

        // Zero in both registers acts as one.
        apply_setting(5'd0, 7'd0);
        send_row(64'hFF, 1'b0);
        send_row(64'h2, 1'b0);
        send_row(64'h1, 1'b1);
        wait_idle();

        // Values above the maximum clamp; a one-row matrix.
        apply_setting(5'd31, 7'd127);
        send_row('1, 1'b1);
        wait_idle();
        apply_setting(5'd17, 7'd65);
        send_row(sorted_row(64), 1'b0);
        send_row(sorted_row(63), 1'b0);
        send_row({$urandom, $urandom}, 1'b1);

        random_start = rows_sent;
        while (rows_sent - random_start < RANDOM_ROWS) begin
            if (matrices_sent % 4 == 0) begin
                wait_idle();
                apply_setting(pick_k(), pick_cols());
                if (!hold_start && rows_sent - random_start > 100)
                    hold_start <= 1'b1;
            end
            send_matrix(($urandom_range(0, 3) == 0) ? $urandom_range(17, 28)
                                                    : $urandom_range(1, 12));
        end

        wait_idle();
        $display("Sent %0d rows in %0d matrices under %0d register settings.",
                 rows_sent, matrices_sent, settings_used);
        $display("Checked %0d reported words, including a long output hold-off.",
                 board.words_checked);
        if (board.mismatches == 0 && board.pending_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/kwr_pkg.sv
rtl/core/kwr_front.sv
rtl/core/kwr_queue.sv
rtl/core/kwr_back.sv
rtl/core/k_weakest_rows_select.sv
tb/kwr_board_pkg.sv
tb/tb_top.sv
